// ----- design/bks_pkg.sv -----
// Package for the bounded key stack: opcodes, status codes, payload structs
// and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package bks_pkg;

  localparam int unsigned DepthDefault   = 32;
  localparam int unsigned KeyBitsDefault = 64;
  localparam int unsigned MaxResults     = 32;
  localparam int unsigned NumBits        = $clog2(MaxResults);
  localparam int unsigned KeepBits       = 6;
  localparam logic [KeepBits-1:0] KeepReset = 6'd10;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_DISPLAY = 3'd4,
    OP_TRUNC   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_DUP   = 3'd3,
    ST_MISS  = 3'd4
  } status_e;

  typedef struct packed {
    op_e         opcode;
    logic [63:0] key;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] entry_key;
    logic [4:0]  entry_pos;
    logic        last;
  } out_t;

  typedef struct packed {
    logic load;       // capture the accepted item
    logic scan_run;   // step the membership scan
    logic rd_top;     // read the top entry
    logic rd_disp;    // read at the display pointer
    logic disp_init;  // set the display pointer to the top
    logic emit_resp;  // load the single result and update the stack
    logic emit_disp;  // load one display result and step down
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic scan_busy;
    logic out_free;
    logic disp_last;
  } sts_t;

endpackage

// ----- design/bks_dpath.sv -----
// Datapath of the bounded key stack: entry memory, fill count, keep_count
// register, scan and display counters, output register.
// Depends on bks_pkg.
`timescale 1ns / 1ps

module bks_dpath import bks_pkg::*; #(
  parameter int unsigned DEPTH    = DepthDefault,
  parameter int unsigned KEY_BITS = KeyBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_t                 in_data_i,
  input  logic                cfg_we_i,
  input  logic [KeepBits-1:0] cfg_wdata_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > KeepBits) ? CW : KeepBits;

  logic [KEY_BITS-1:0] mem_q [DEPTH];
  logic [KEY_BITS-1:0] rdata_q;
  logic [IW-1:0]       raddr;
  logic                wen;

  op_e                 op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CW-1:0]       fill_q, fill_d;
  logic [KeepBits-1:0] keep_q;
  logic [CW-1:0]       scan_q;
  logic                rd_vld_q;
  logic                hit_q;
  logic [IW-1:0]       disp_q;
  logic [NumBits-1:0]  num_q;
  logic                issuing;
  logic                full;
  logic                out_valid_q;
  out_t                out_q;
  out_t                res;

  assign issuing = cmd_i.scan_run && (scan_q < fill_q);
  assign full    = (fill_q >= CW'(DEPTH));

  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.scan_busy = (scan_q < fill_q) || rd_vld_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.disp_last = (disp_q == '0) || (num_q == NumBits'(MaxResults - 1));

  always_comb begin
    if (cmd_i.rd_disp) begin
      raddr = disp_q;
    end else if (cmd_i.rd_top) begin
      raddr = IW'(fill_q - CW'(1));
    end else begin
      raddr = scan_q[IW-1:0];
    end
  end

  assign wen = cmd_i.emit_resp && (op_q == OP_PUSH) && !hit_q && !full;

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[fill_q[IW-1:0]] <= key_q;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i.opcode;
      key_q <= in_data_i.key[KEY_BITS-1:0];
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.load && (in_data_i.opcode == OP_TRUNC) &&
        (CMPW'(fill_q) > CMPW'(keep_q))) begin
      fill_d = CW'(keep_q);
    end else if (wen) begin
      fill_d = fill_q + CW'(1);
    end else if (cmd_i.emit_resp && (op_q == OP_POP) && !sts_o.fill_zero) begin
      fill_d = fill_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      keep_q   <= KeepReset;
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      disp_q   <= '0;
      num_q    <= '0;
    end else begin
      fill_q <= fill_d;
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
      rd_vld_q <= issuing;
      if (cmd_i.load) begin
        scan_q <= '0;
        hit_q  <= 1'b0;
      end else begin
        if (issuing) begin
          scan_q <= scan_q + CW'(1);
        end
        if (rd_vld_q && (rdata_q == key_q)) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.disp_init) begin
        disp_q <= IW'(fill_q - CW'(1));
        num_q  <= '0;
      end else if (cmd_i.emit_disp) begin
        disp_q <= disp_q - IW'(1);
        num_q  <= num_q + NumBits'(1);
      end
    end
  end

  always_comb begin
    res           = '0;
    res.status    = ST_OK;
    res.last      = 1'b1;
    if (cmd_i.emit_disp) begin
      res.entry_key = 64'(rdata_q);
      res.entry_pos = 5'(disp_q);
      res.last      = sts_o.disp_last;
    end else begin
      case (op_q)
        OP_PUSH: begin
          if (hit_q) begin
            res.status = ST_DUP;
          end else if (full) begin
            res.status = ST_FULL;
          end
        end
        OP_POP, OP_PEEK: begin
          if (sts_o.fill_zero) begin
            res.status = ST_EMPTY;
          end else begin
            res.entry_key = 64'(rdata_q);
            res.entry_pos = 5'(fill_q - CW'(1));
          end
        end
        OP_SEARCH: begin
          res.status = hit_q ? ST_OK : ST_MISS;
        end
        default: begin
          // display or truncate of an empty stack
          res.status = ST_EMPTY;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_resp || cmd_i.emit_disp) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_resp || cmd_i.emit_disp) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_resp || cmd_i.emit_disp) |-> sts_o.out_free)
    else $error("result loaded over an unaccepted item");

  a_dup_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_resp && (op_q == OP_PUSH) && hit_q) |=> fill_q == $past(fill_q))
    else $error("duplicate push changed the stack");

  a_pop_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_resp && (op_q == OP_POP) && !sts_o.fill_zero)
      |=> fill_q == $past(fill_q) - CW'(1))
    else $error("pop did not drop the top entry");
`endif

endmodule

// ----- design/bks_ctrl.sv -----
// Controller of the bounded key stack: sequences scan, read, display and
// result loading for one item at a time. Depends on bks_pkg.
`timescale 1ns / 1ps

module bks_ctrl import bks_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  op_e  op_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_RESP   = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DREAD  = 3'd5;
  localparam logic [2:0] S_DEMIT  = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (op_i)
            OP_PUSH, OP_SEARCH:  state_d = S_SCAN;
            OP_POP, OP_PEEK:     state_d = sts_i.fill_zero ? S_RESP : S_READ;
            OP_DISPLAY, OP_TRUNC: state_d = S_DSTART;
            default:             state_d = S_IDLE;  // drop unused opcodes
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (!sts_i.scan_busy) begin
          state_d = S_RESP;
        end
      end
      S_READ: begin
        cmd_o.rd_top = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        cmd_o.rd_top = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit_resp = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_DSTART: begin
        cmd_o.disp_init = 1'b1;
        state_d         = sts_i.fill_zero ? S_RESP : S_DREAD;
      end
      S_DREAD: begin
        cmd_o.rd_disp = 1'b1;
        state_d       = S_DEMIT;
      end
      S_DEMIT: begin
        cmd_o.rd_disp = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit_disp = 1'b1;
          state_d         = sts_i.disp_last ? S_IDLE : S_DREAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_disp_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_disp && sts_i.disp_last) |=> in_ready_o)
    else $error("display did not end on its last item");

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.emit_resp && cmd_o.emit_disp))
    else $error("two results loaded at once");

  a_resp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_resp |=> state_q == S_IDLE)
    else $error("single-result item did not finish");
`endif

endmodule

// ----- design/bounded_key_stack_with_search.sv -----
// Bounded LIFO stack of keys with membership search: top level.
// Instantiates bks_ctrl and bks_dpath; depends on bks_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one item: opcode
//   and key. Output channel (out_valid_o/out_ready_i/out_data_o) gives the
//   result items, the final one of each input with last set. keep_count is
//   to be written through cfg_we_i/cfg_wdata_i while the block is idle;
//   the block does not enforce this. One item is worked on at a time;
//   in_ready_o rises once the previous item has loaded its final result
//   into the output register. Steps, with N stored entries:
//     push, search         scan of the N entries, one memory read per
//                          cycle, compare on the registered read data
//     pop, peek            read of the top entry, skipped when empty
//     display, truncate    pointer set to the top, then for each result
//                          a read then a load, at most 32 results
//   Reset empties the stack and sets keep_count to 10; the entry memory is
//   not cleared. When the receiver stalls the result waits in the output
//   register and the sequencer holds until it is taken.
`timescale 1ns / 1ps

module bounded_key_stack_with_search import bks_pkg::*; #(
  parameter int unsigned DEPTH    = DepthDefault,
  parameter int unsigned KEY_BITS = KeyBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [KeepBits-1:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  bks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (in_data_i.opcode),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bks_dpath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
